/* src/ffea_pkg.sv */
// Shared constants and types for the first-fit extent allocator.
package ffea_pkg;
	localparam int unsigned MaxExtentsDefault = 64;
	localparam int unsigned AddrBitsDefault = 32;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_FORMAT = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_NOFIT = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	localparam logic [1:0] REG_POOL_BASE = 2'd0;
	localparam logic [1:0] REG_POOL_LIMIT = 2'd1;
	localparam logic [1:0] REG_MIN_FRAG = 2'd2;
endpackage

/* src/first_fit_extent_allocator.sv */
// First-fit extent allocator top level: extent table memory and its sequencer.
//
// One operation is in progress at a time; in_ready is low while it runs.
// Each step does one read of the extent memory (start and end kept in one
// word) and one write, so every entry scanned is read, then compared, and
// every entry shifted is read, then written.
// Allocate and free scan up to the count of extents n held before the
// operation, then removal or insertion shifts the entries above the hit.
// The worst case is a free that inserts a new extent near the front.
// Format, opcode 3, a zero request and an empty range go straight to the
// done state. The result waits in an output register; the next transaction
// is taken once it has been delivered.
module first_fit_extent_allocator
	import ffea_pkg::*;
#(
	parameter int unsigned MAX_EXTENTS = MaxExtentsDefault,
	parameter int unsigned ADDR_BITS = AddrBitsDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               opcode,
	input  logic [31:0]              req_size,
	input  logic [31:0]              range_start,
	input  logic [31:0]              range_end,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [31:0]              alloc_addr,
	output logic [1:0]               status,
	output logic [6:0]               extent_total,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [31:0]              cfg_data
);
	localparam int unsigned IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
	localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
	localparam int unsigned AW = ADDR_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_SCAN, S_FREE_PREV, S_FREE_DEC, S_RM_RD, S_RM_WR,
		S_INS_RD, S_INS_WR, S_DONE
	} state_t;

	logic [2*AW-1:0] mem [MAX_EXTENTS];
	logic [2*AW-1:0] rd_data;
	logic [IW-1:0]   rd_addr;
	logic            rd_en;
	logic [IW-1:0]   wr_addr;
	logic [2*AW-1:0] wr_data;
	logic            wr_en;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem[rd_addr];
	end

	state_t         state_q;
	logic [AW-1:0]  base_q, limit_q;
	logic [7:0]     minf_q;
	logic [1:0]     op_q;
	logic [AW-1:0]  size_q, rs_q, re_q;
	logic [CW-1:0]  cnt_q;
	logic [CW-1:0]  idx_q;
	logic [CW-1:0]  pos_q;
	logic [AW-1:0]  prev_end_q;
	logic [AW-1:0]  next_end_q;
	logic [2*AW-1:0] carry_q;
	logic [31:0]    addr_q;
	logic [1:0]     st_q;
	logic           ovalid_q;

	logic [AW-1:0] e_start, e_end, avail, rem;
	assign e_start = rd_data[AW-1:0];
	assign e_end = rd_data[2*AW-1:AW];
	assign avail = e_end - e_start;
	assign rem = avail - size_q;

	logic [AW-1:0] ext_size, ext_rs, ext_re;
	logic [AW+31:0] w_size, w_rs, w_re;
	assign w_size = {{AW{1'b0}}, req_size};
	assign w_rs = {{AW{1'b0}}, range_start};
	assign w_re = {{AW{1'b0}}, range_end};
	assign ext_size = w_size[AW-1:0];
	assign ext_rs = w_rs[AW-1:0];
	assign ext_re = w_re[AW-1:0];

	logic [AW+31:0] w_cfg;
	logic [AW+31:0] w_addr_out;
	assign w_cfg = {{AW{1'b0}}, cfg_data};
	assign w_addr_out = {{32{1'b0}}, e_start};

	assign in_ready = (state_q == S_IDLE) && !ovalid_q;
	assign out_valid = ovalid_q;
	assign alloc_addr = addr_q;
	assign status = st_q;
	assign extent_total = 7'(cnt_q);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = idx_q[IW-1:0];
		wr_en = 1'b0;
		wr_addr = idx_q[IW-1:0];
		wr_data = rd_data;
		case (state_q)
			S_RD, S_RM_RD, S_INS_RD: rd_en = 1'b1;
			S_IDLE: begin
				if (in_valid && in_ready && opcode == OP_FORMAT &&
					base_q < limit_q) begin
					wr_en = 1'b1;
					wr_addr = '0;
					wr_data = {limit_q, base_q};
				end
			end
			S_SCAN: begin
				if (op_q == OP_ALLOC && avail >= size_q && rem != '0 &&
					{{(AW-8){1'b0}}, minf_q} <= rem) begin
					wr_en = 1'b1;
					wr_data = {e_end, e_start + size_q};
				end
			end
			S_FREE_PREV: begin
				wr_en = 1'b1;
				wr_addr = IW'(pos_q - 1'b1);
				wr_data = {re_q, prev_end_q};
			end
			S_FREE_DEC: begin
				wr_en = 1'b1;
				wr_addr = pos_q[IW-1:0];
				wr_data = {next_end_q, rs_q};
			end
			S_RM_WR: begin
				wr_en = 1'b1;
				wr_addr = IW'(idx_q - 1'b1);
			end
			S_INS_WR: begin
				wr_en = 1'b1;
				wr_data = carry_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			base_q <= '0;
			limit_q <= AW'(1048576);
			minf_q <= 8'd12;
			cnt_q <= '0;
			ovalid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_POOL_BASE: base_q <= w_cfg[AW-1:0];
					REG_POOL_LIMIT: limit_q <= w_cfg[AW-1:0];
					REG_MIN_FRAG: minf_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						op_q <= opcode;
						size_q <= ext_size;
						rs_q <= ext_rs;
						re_q <= ext_re;
						idx_q <= '0;
						addr_q <= '0;
						case (opcode)
							OP_ALLOC: begin
								if (ext_size == '0 || cnt_q == '0) begin
									st_q <= ST_NOFIT;
									state_q <= S_DONE;
								end else begin
									st_q <= ST_OK;
									state_q <= S_RD;
								end
							end
							OP_FREE: begin
								if (ext_rs >= ext_re) begin
									st_q <= ST_EMPTY;
									state_q <= S_DONE;
								end else if (cnt_q == '0) begin
									st_q <= ST_OK;
									pos_q <= '0;
									state_q <= S_INS_RD;
									carry_q <= {ext_re, ext_rs};
								end else begin
									st_q <= ST_OK;
									state_q <= S_RD;
								end
							end
							OP_FORMAT: begin
								if (base_q < limit_q) begin
									cnt_q <= CW'(1);
									st_q <= ST_OK;
								end else begin
									cnt_q <= '0;
									st_q <= ST_EMPTY;
								end
								state_q <= S_DONE;
							end
							default: begin
								st_q <= ST_OK;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RD: state_q <= S_SCAN;
				S_SCAN: begin
					if (op_q == OP_ALLOC) begin
						if (avail >= size_q) begin
							addr_q <= w_addr_out[31:0];
							if (rem != '0 && {{(AW-8){1'b0}}, minf_q} <= rem)
								state_q <= S_DONE;
							else begin
								idx_q <= idx_q + 1'b1;
								state_q <= S_RM_RD;
							end
						end else if (idx_q + 1'b1 == cnt_q) begin
							st_q <= ST_NOFIT;
							state_q <= S_DONE;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= S_RD;
						end
					end else begin
						if (e_start <= rs_q) begin
							if (idx_q + 1'b1 == cnt_q) begin
								pos_q <= idx_q + 1'b1;
								if (e_end == rs_q) begin
									prev_end_q <= e_start;
									state_q <= S_FREE_PREV;
								end else if (cnt_q >= CW'(MAX_EXTENTS)) begin
									st_q <= ST_FULL;
									state_q <= S_DONE;
								end else begin
									carry_q <= {re_q, rs_q};
									idx_q <= idx_q + 1'b1;
									state_q <= S_INS_WR;
								end
							end else begin
								carry_q <= rd_data;
								idx_q <= idx_q + 1'b1;
								state_q <= S_RD;
							end
						end else begin
							// pos = idx; prev = idx-1 (carry_q holds it when idx>0)
							pos_q <= idx_q;
							next_end_q <= e_end;
							if (idx_q != '0 && carry_q[2*AW-1:AW] == rs_q &&
								re_q == e_start) begin
								prev_end_q <= carry_q[AW-1:0];
								re_q <= e_end;
								idx_q <= idx_q + 1'b1;
								state_q <= S_FREE_PREV;
							end else if (idx_q != '0 && carry_q[2*AW-1:AW] == rs_q) begin
								prev_end_q <= carry_q[AW-1:0];
								state_q <= S_FREE_PREV;
							end else if (re_q == e_start) begin
								state_q <= S_FREE_DEC;
							end else if (cnt_q >= CW'(MAX_EXTENTS)) begin
								st_q <= ST_FULL;
								state_q <= S_DONE;
							end else begin
								carry_q <= {re_q, rs_q};
								state_q <= S_INS_RD;
							end
						end
					end
				end
				S_FREE_PREV: begin
					if (idx_q == pos_q + 1'b1 && re_q == next_end_q) begin
						if (idx_q == cnt_q) begin
							cnt_q <= cnt_q - 1'b1;
							state_q <= S_DONE;
						end else state_q <= S_RM_RD;
					end else state_q <= S_DONE;
				end
				S_FREE_DEC: state_q <= S_DONE;
				S_RM_RD: begin
					if (idx_q == cnt_q) begin
						cnt_q <= cnt_q - 1'b1;
						state_q <= S_DONE;
					end else state_q <= S_RM_WR;
				end
				S_RM_WR: begin
					idx_q <= idx_q + 1'b1;
					state_q <= S_RM_RD;
				end
				S_INS_RD: begin
					if (idx_q == cnt_q) state_q <= S_INS_WR;
					else state_q <= S_INS_WR;
				end
				S_INS_WR: begin
					if (idx_q == cnt_q) begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_DONE;
					end else begin
						carry_q <= rd_data;
						idx_q <= idx_q + 1'b1;
						state_q <= S_INS_RD;
					end
				end
				S_DONE: begin
					ovalid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* src/ffea_checker.sv */
// Port-level checker for the first-fit extent allocator, bound to the top level.
module ffea_checker
	import ffea_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] alloc_addr,
	input logic [1:0]  status,
	input logic [6:0]  extent_total
);
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input taken while result pending");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready right after transaction");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(alloc_addr))
		else $error("result dropped");
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> alloc_addr == '0)
		else $error("address on failure");
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> extent_total <= 7'd64) else $error("count out of range");
endmodule

bind first_fit_extent_allocator ffea_checker u_ffea_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .alloc_addr(alloc_addr),
	.status(status), .extent_total(extent_total)
);
